// ----- hdl/mf3_pkg.sv -----
// shared types and constants of the 3x3 median filter
package mf3_pkg;

	localparam int MF3_MAX_WIDTH = 1024;
	localparam int MAX_HEIGHT    = 4096;
	localparam int MIN_DIM       = 3;

	localparam int PIX_BITS      = 8;
	localparam int IMG_W_BITS    = 11;
	localparam int IMG_H_BITS    = 13;
	localparam int ROW_BITS      = 12;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 13;
	localparam int WIN_TAPS      = 9;

	localparam int Q_DEPTH       = 4;
	localparam int Q_CNT_BITS    = $clog2(Q_DEPTH + 1);
	localparam int OUT_DEPTH     = 4;

	localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH    = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT   = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_BAND_FIRST_ROW = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_BAND_END_ROW   = 2'd3;

	localparam logic [IMG_W_BITS-1:0] RST_IMAGE_WIDTH    = 11'd1024;
	localparam logic [IMG_H_BITS-1:0] RST_IMAGE_HEIGHT   = 13'd4096;
	localparam logic [IMG_H_BITS-1:0] RST_BAND_FIRST_ROW = 13'd0;
	localparam logic [IMG_H_BITS-1:0] RST_BAND_END_ROW   = 13'd4096;

	// window[3*col + row], col 0 oldest, row 0 top
	typedef logic [WIN_TAPS-1:0][PIX_BITS-1:0] win_t;

	typedef struct packed {
		win_t win;
		logic last;
	} item_t;

	typedef struct packed {
		logic [IMG_W_BITS-1:0] image_width;
		logic [IMG_H_BITS-1:0] image_height;
		logic [IMG_H_BITS-1:0] band_first_row;
		logic [IMG_H_BITS-1:0] band_end_row;
	} cfg_t;

endpackage

// ----- hdl/mf3_ram.sv -----
// generic single write port ram with registered read
module mf3_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hdl/mf3_queue.sv -----
// small register queue used between the filter parts and at the result side
module mf3_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           wdata,
	input  logic                       pop,
	output logic [WIDTH-1:0]           rdata,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign do_push = push && (count_q != CW'(DEPTH));
	assign do_pop  = pop && (count_q != '0);
	assign rdata   = mem_q[rd_ptr_q];
	assign count   = count_q;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- hdl/mf3_front.sv -----
// front part: position counters, line stores, window and emit decision
module mf3_front import mf3_pkg::*; #(
	parameter int MAX_WIDTH = MF3_MAX_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [PIX_BITS-1:0]   pixel,
	input  cfg_t                  cfg,
	input  logic [Q_CNT_BITS-1:0] q_count,
	output logic                  q_push,
	output item_t                 q_item
);

	localparam int CB = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int CW = (WW > IMG_W_BITS) ? WW : IMG_W_BITS;

	logic [CB-1:0]         col_q;
	logic [ROW_BITS-1:0]   row_q;
	logic [CW-1:0]         w_raw;
	logic [WW-1:0]         w_eff;
	logic [WW-1:0]         w_m1;
	logic [IMG_H_BITS-1:0] h_eff;
	logic [IMG_H_BITS-1:0] h_m1;
	logic [IMG_H_BITS-1:0] stop_row;
	logic [IMG_H_BITS-1:0] centre;
	logic [WW-1:0]         col_inc;
	logic [IMG_H_BITS-1:0] row_inc;
	logic                  interior;
	logic                  in_band;
	logic                  accept;

	logic                  valid_s1;
	logic                  emit_s1;
	logic                  last_s1;
	logic [PIX_BITS-1:0]   px_s1;
	logic [CB-1:0]         addr_s1;
	logic [PIX_BITS-1:0]   rd_a;
	logic [PIX_BITS-1:0]   rd_b;
	win_t                  window_q;
	win_t                  win_next;

	// clamp the configured geometry
	always_comb begin
		w_raw = CW'(cfg.image_width);
		if (w_raw < CW'(MIN_DIM)) begin
			w_eff = WW'(MIN_DIM);
		end else if (w_raw > CW'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(w_raw);
		end
		if (cfg.image_height < IMG_H_BITS'(MIN_DIM)) begin
			h_eff = IMG_H_BITS'(MIN_DIM);
		end else if (cfg.image_height > IMG_H_BITS'(MAX_HEIGHT)) begin
			h_eff = IMG_H_BITS'(MAX_HEIGHT);
		end else begin
			h_eff = cfg.image_height;
		end
		w_m1     = w_eff - 1'b1;
		h_m1     = h_eff - 1'b1;
		stop_row = (cfg.band_end_row < h_m1) ? cfg.band_end_row : h_m1;
	end

	always_comb begin
		centre   = IMG_H_BITS'(row_q) - 1'b1;
		interior = (row_q >= ROW_BITS'(2)) && (IMG_H_BITS'(row_q) <= h_m1)
			&& (col_q >= CB'(2)) && (WW'(col_q) <= w_m1);
		in_band  = (centre >= cfg.band_first_row) && (centre < cfg.band_end_row);
		col_inc  = WW'(col_q) + 1'b1;
		row_inc  = IMG_H_BITS'(row_q) + 1'b1;
	end

	// one entry of the queue is reserved for the request in s1
	assign full   = (({1'b0, q_count} + (Q_CNT_BITS+1)'(valid_s1)) >=
		(Q_CNT_BITS+1)'(Q_DEPTH));
	assign accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				if (col_inc >= w_eff) begin
					col_q <= '0;
					row_q <= (row_inc >= h_eff) ? '0 : row_inc[ROW_BITS-1:0];
				end else begin
					col_q <= col_inc[CB-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			emit_s1 <= interior && in_band;
			last_s1 <= (WW'(col_q) == w_m1) && (IMG_H_BITS'(row_q) == stop_row);
			px_s1   <= pixel;
			addr_s1 <= col_q;
		end
	end

	// line store a holds the previous row, b the row before it
	mf3_ram #(
		.WIDTH (PIX_BITS),
		.DEPTH (MAX_WIDTH)
	) u_line_a (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (addr_s1),
		.wdata (px_s1),
		.re    (accept),
		.raddr (col_q),
		.rdata (rd_a)
	);

	mf3_ram #(
		.WIDTH (PIX_BITS),
		.DEPTH (MAX_WIDTH)
	) u_line_b (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (addr_s1),
		.wdata (rd_a),
		.re    (accept),
		.raddr (col_q),
		.rdata (rd_b)
	);

	always_comb begin
		win_next    = window_q;
		win_next[0] = window_q[3];
		win_next[1] = window_q[4];
		win_next[2] = window_q[5];
		win_next[3] = window_q[6];
		win_next[4] = window_q[7];
		win_next[5] = window_q[8];
		win_next[6] = rd_b;
		win_next[7] = rd_a;
		win_next[8] = px_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (valid_s1) begin
			window_q <= win_next;
		end
	end

	assign q_push      = valid_s1 && emit_s1;
	assign q_item.win  = win_next;
	assign q_item.last = last_s1;

endmodule

// ----- hdl/mf3_back.sv -----
// back part: pipelined median sorting network and result queue
module mf3_back import mf3_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [Q_CNT_BITS-1:0] q_count,
	input  item_t                 q_item,
	output logic                  q_pop,
	output logic                  empty,
	input  logic                  pop,
	output logic [PIX_BITS-1:0]   median,
	output logic                  last_of_frame
);

	localparam int OCW = $clog2(OUT_DEPTH + 1);

	function automatic win_t sort_pair(input win_t v, input logic [3:0] i,
		input logic [3:0] j);
		win_t r;
		r = v;
		if (v[i] > v[j]) begin
			r[i] = v[j];
			r[j] = v[i];
		end
		return r;
	endfunction

	// sort each column of three
	function automatic win_t sort_cols(input win_t v);
		win_t r;
		r = sort_pair(v, 4'd1, 4'd2);
		r = sort_pair(r, 4'd4, 4'd5);
		r = sort_pair(r, 4'd7, 4'd8);
		r = sort_pair(r, 4'd0, 4'd1);
		r = sort_pair(r, 4'd3, 4'd4);
		r = sort_pair(r, 4'd6, 4'd7);
		r = sort_pair(r, 4'd1, 4'd2);
		r = sort_pair(r, 4'd4, 4'd5);
		r = sort_pair(r, 4'd7, 4'd8);
		return r;
	endfunction

	function automatic win_t sort_mid(input win_t v);
		win_t r;
		r = sort_pair(v, 4'd0, 4'd3);
		r = sort_pair(r, 4'd5, 4'd8);
		r = sort_pair(r, 4'd4, 4'd7);
		r = sort_pair(r, 4'd3, 4'd6);
		r = sort_pair(r, 4'd1, 4'd4);
		r = sort_pair(r, 4'd2, 4'd5);
		r = sort_pair(r, 4'd4, 4'd7);
		return r;
	endfunction

	function automatic win_t sort_last(input win_t v);
		win_t r;
		r = sort_pair(v, 4'd4, 4'd2);
		r = sort_pair(r, 4'd6, 4'd4);
		r = sort_pair(r, 4'd4, 4'd2);
		return r;
	endfunction

	logic                 v_s1;
	logic                 v_s2;
	win_t                 win_s1;
	win_t                 win_s2;
	logic                 last_s1;
	logic                 last_s2;
	win_t                 win_fin;
	logic [OCW-1:0]       out_count;
	logic [PIX_BITS:0]    out_data;

	// take a request only when the result queue has room for all in flight
	assign q_pop = (q_count != '0) &&
		((OCW+1)'(out_count) + (OCW+1)'(v_s1) + (OCW+1)'(v_s2) < (OCW+1)'(OUT_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= q_pop;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		win_s1  <= sort_cols(q_item.win);
		last_s1 <= q_item.last;
		win_s2  <= sort_mid(win_s1);
		last_s2 <= last_s1;
	end

	assign win_fin = sort_last(win_s2);

	mf3_queue #(
		.WIDTH (PIX_BITS + 1),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (v_s2),
		.wdata  ({win_fin[4], last_s2}),
		.pop    (pop && !empty),
		.rdata  (out_data),
		.count  (out_count)
	);

	assign empty         = (out_count == '0);
	assign median        = out_data[PIX_BITS:1];
	assign last_of_frame = out_data[0];

endmodule

// ----- hdl/median_filter_3x3_core.sv -----
// top level of the streaming 3x3 median filter
// Pixels enter in raster order at one per clock while full is low and a result can leave at
// one per clock while empty is low; a result reaches the result ports after its pixel is
// taken by way of the line store read, the queue between the parts and two register stages
// of the sorting network whose last compare layers sit ahead of the result queue. One pixel
// per clock holds because each line store has a read port and a write port, read once and
// written once per pixel. Only interior pixels whose centre row lies in the configured band
// give a result; the last one of a frame carries last_of_frame. full rises when the result
// side stops popping and the internal queues fill. Configuration must be written only while
// the filter is idle; the block itself does not enforce this. The line stores are not cleared.
module median_filter_3x3_core import mf3_pkg::*; #(
	parameter int MAX_WIDTH = MF3_MAX_WIDTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic [PIX_BITS-1:0]      pixel,
	output logic                     empty,
	input  logic                     pop,
	output logic [PIX_BITS-1:0]      median,
	output logic                     last_of_frame,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	cfg_t                  cfg_q;
	logic                  q_push;
	item_t                 q_wr_item;
	item_t                 q_rd_item;
	logic                  q_pop;
	logic [Q_CNT_BITS-1:0] q_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width    <= RST_IMAGE_WIDTH;
			cfg_q.image_height   <= RST_IMAGE_HEIGHT;
			cfg_q.band_first_row <= RST_BAND_FIRST_ROW;
			cfg_q.band_end_row   <= RST_BAND_END_ROW;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:    cfg_q.image_width    <= cfg_data[IMG_W_BITS-1:0];
				REG_IMAGE_HEIGHT:   cfg_q.image_height   <= cfg_data[IMG_H_BITS-1:0];
				REG_BAND_FIRST_ROW: cfg_q.band_first_row <= cfg_data[IMG_H_BITS-1:0];
				REG_BAND_END_ROW:   cfg_q.band_end_row   <= cfg_data[IMG_H_BITS-1:0];
				default:            cfg_q                <= cfg_q;
			endcase
		end
	end

	mf3_front #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.pixel   (pixel),
		.cfg     (cfg_q),
		.q_count (q_count),
		.q_push  (q_push),
		.q_item  (q_wr_item)
	);

	mf3_queue #(
		.WIDTH ($bits(item_t)),
		.DEPTH (Q_DEPTH)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wr_item),
		.pop    (q_pop),
		.rdata  (q_rd_item),
		.count  (q_count)
	);

	mf3_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_count       (q_count),
		.q_item        (q_rd_item),
		.q_pop         (q_pop),
		.empty         (empty),
		.pop           (pop),
		.median        (median),
		.last_of_frame (last_of_frame)
	);

endmodule

// ----- hdl/mf3_checker.sv -----
// port-level checks of the median filter, bound to the top level
module mf3_checker import mf3_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                push,
	input logic                full,
	input logic                empty,
	input logic                pop,
	input logic [PIX_BITS-1:0] median,
	input logic                last_of_frame
);

	logic seen_q;

	// sticky: some pixel was taken since reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else if (push && !full) begin
			seen_q <= 1'b1;
		end
	end

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty)
		else $error("waiting result vanished");

	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> $stable(median) && $stable(last_of_frame))
		else $error("waiting result changed");

	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(empty) |-> $past(seen_q, 3))
		else $error("result appeared before any pixel could reach it");

	a_full_needs_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push && !full))
		else $error("full rose without a pixel taken");

endmodule

bind median_filter_3x3_core mf3_checker u_mf3_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.push          (push),
	.full          (full),
	.empty         (empty),
	.pop           (pop),
	.median        (median),
	.last_of_frame (last_of_frame)
);

// ----- bench/tb.sv -----
// self-checking bench for the 3x3 median filter core: random frames, band limits and back-pressure
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mf3_pkg::*;

	localparam int IDLE_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;
	localparam int ITEM_TARGET = 1600;

	typedef struct packed {
		logic [PIX_BITS-1:0] median;
		logic                last;
	} median_rec_t;

	logic                     clk;
	logic                     arst_n = 1'b0;
	logic                     push = 1'b0;
	logic                     full;
	logic [PIX_BITS-1:0]      pixel = '0;
	logic                     empty;
	logic                     pop = 1'b0;
	logic [PIX_BITS-1:0]      median;
	logic                     last_of_frame;
	logic                     cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	median_filter_3x3_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.pixel(pixel),
		.empty(empty),
		.pop(pop),
		.median(median),
		.last_of_frame(last_of_frame),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// pixels waiting to be offered and medians waiting to come out
	logic [PIX_BITS-1:0] pending [$];
	median_rec_t         median_due [$];
	int                  mismatches = 0;
	int                  queued = 0;

	// filter image kept by the bench
	logic [IMG_W_BITS-1:0] cfg_width = RST_IMAGE_WIDTH;
	logic [IMG_H_BITS-1:0] cfg_height = RST_IMAGE_HEIGHT;
	logic [IMG_H_BITS-1:0] cfg_first = RST_BAND_FIRST_ROW;
	logic [IMG_H_BITS-1:0] cfg_end = RST_BAND_END_ROW;
	logic [PIX_BITS-1:0]   line_prev [MF3_MAX_WIDTH];
	logic [PIX_BITS-1:0]   line_older [MF3_MAX_WIDTH];
	logic [PIX_BITS-1:0]   win_taps [WIN_TAPS];
	int unsigned           col_pos = 0;
	int unsigned           row_pos = 0;

	logic hold_arm = 1'b0;
	int   in_gap, in_calm, out_gap, out_calm, hold_left;
	logic hold_taken;
	int   idle_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned clamp_dim(input int unsigned value, input int unsigned hi);
		if (value < MIN_DIM)
			return MIN_DIM;
		if (value > hi)
			return hi;
		return value;
	endfunction

	function automatic int draw_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		else if (p < 85)
			return $urandom_range(1, 3);
		else if (p < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// add one pixel to the offer queue
	task automatic queue_pixel(input logic [PIX_BITS-1:0] px);
		pending = {pending, px};
		queued++;
	endtask

	task automatic queue_median(input median_rec_t rec);
		median_due = {median_due, rec};
	endtask

	// advance the filter image by one pixel and queue the median it produces, if any
	task automatic filter_pixel(input logic [PIX_BITS-1:0] px);
		int unsigned         w, h, c, r, idx, stop, centre;
		logic [PIX_BITS-1:0] top, mid, key;
		logic [PIX_BITS-1:0] srt [WIN_TAPS];
		int                  i, j;
		median_rec_t         rec;
		w = clamp_dim(cfg_width, MF3_MAX_WIDTH);
		h = clamp_dim(cfg_height, MAX_HEIGHT);
		c = col_pos;
		r = row_pos;
		idx = c % MF3_MAX_WIDTH;
		top = line_older[idx];
		mid = line_prev[idx];
		line_older[idx] = mid;
		line_prev[idx] = px;
		for (i = 0; i < 6; i++)
			win_taps[i] = win_taps[i + 3];
		win_taps[6] = top;
		win_taps[7] = mid;
		win_taps[8] = px;
		if (r >= 2 && r <= h - 1 && c >= 2 && c <= w - 1) begin
			centre = r - 1;
			if (centre >= cfg_first && centre < cfg_end) begin
				stop = (cfg_end < h - 1) ? cfg_end : h - 1;
				srt = win_taps;
				for (i = 1; i < WIN_TAPS; i++) begin
					key = srt[i];
					for (j = i - 1; j >= 0 && srt[j] > key; j--)
						srt[j + 1] = srt[j];
					srt[j + 1] = key;
				end
				rec.median = srt[4];
				rec.last = (c == w - 1 && r == stop);
				queue_median(rec);
			end
		end
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h)
				r = 0;
		end
		col_pos = c;
		row_pos = r;
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] which, input int unsigned value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= which;
		cfg_data <= value[CFG_DATA_BITS-1:0];
		case (which)
			REG_IMAGE_WIDTH:    cfg_width = value[IMG_W_BITS-1:0];
			REG_IMAGE_HEIGHT:   cfg_height = value[IMG_H_BITS-1:0];
			REG_BAND_FIRST_ROW: cfg_first = value[IMG_H_BITS-1:0];
			REG_BAND_END_ROW:   cfg_end = value[IMG_H_BITS-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// random value of a kind that keeps frames short
	task automatic shuffle_reg(input logic [CFG_IDX_BITS-1:0] which);
		int p;
		int unsigned v;
		p = $urandom_range(0, 9);
		case (which)
			REG_IMAGE_WIDTH: begin
				if (p < 7)
					v = $urandom_range(3, 12);
				else if (p < 8)
					v = $urandom_range(0, 2);
				else
					v = 32'h1800 | $urandom_range(3, 12); // bits above the register are dropped
			end
			REG_IMAGE_HEIGHT: begin
				if (p < 8)
					v = $urandom_range(3, 10);
				else
					v = $urandom_range(0, 2);
			end
			REG_BAND_FIRST_ROW: begin
				if (p < 6)
					v = $urandom_range(0, 3);
				else if (p < 9)
					v = $urandom_range(0, 12);
				else
					v = $urandom_range(0, 8191);
			end
			default: begin
				if (p < 4)
					v = 8191;
				else if (p < 7)
					v = $urandom_range(1, 12);
				else if (p < 9)
					v = $urandom_range(0, 2);
				else
					v = $urandom_range(0, 8191);
			end
		endcase
		write_reg(which, v);
	endtask

	task automatic queue_pixels(input int n);
		int tie_mode;
		int i;
		tie_mode = ($urandom_range(0, 4) == 0);
		@(negedge clk);
		for (i = 0; i < n; i++) begin
			if (tie_mode) begin
				case ($urandom_range(0, 3))
					0: queue_pixel(8'd0);
					1: queue_pixel(8'd1);
					2: queue_pixel(8'd254);
					default: queue_pixel(8'd255);
				endcase
			end else begin
				queue_pixel(PIX_BITS'($urandom_range(0, 255)));
			end
		end
	endtask

	// block idle: every pixel taken, every median seen, pipeline drained
	task automatic settle();
		while (pending.size() != 0 || median_due.size() != 0)
			@(negedge clk);
		repeat (10) @(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin : pixel_driver
		int g;
		if (!arst_n) begin
			push <= 1'b0;
			pixel <= '0;
			in_gap <= 0;
			in_calm <= 0;
		end else begin
			if (push && !full) begin
				filter_pixel(pixel);
				void'(pending.pop_front());
			end
			if (!push || !full) begin
				if (in_gap != 0) begin
					push <= 1'b0;
					in_gap <= in_gap - 1;
				end else if (pending.size() != 0) begin
					push <= 1'b1;
					pixel <= pending[0];
					if (in_calm != 0) begin
						g = 0;
						in_calm <= in_calm - 1;
					end else begin
						g = draw_gap();
						if ($urandom_range(0, 99) == 0)
							in_calm <= $urandom_range(40, 200);
					end
					in_gap <= g;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : result_monitor
		int          g;
		median_rec_t want;
		if (!arst_n) begin
			pop <= 1'b0;
			out_gap <= 0;
			out_calm <= 0;
			hold_left <= 0;
			hold_taken <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (median_due.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected median %0d last %0d", median, last_of_frame);
					mismatches++;
				end else begin
					want = median_due.pop_front();
					if (median !== want.median || last_of_frame !== want.last) begin
						if (mismatches < 10)
							$display("median exp %0d got %0d, last exp %0d got %0d",
								want.median, median, want.last, last_of_frame);
						mismatches++;
					end
				end
			end
			if (hold_left != 0) begin
				pop <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (hold_arm && !hold_taken) begin
				// long hold-off so the internal queues fill and full rises
				pop <= 1'b0;
				hold_left <= HOLD_CYCLES;
				hold_taken <= 1'b1;
			end else if (!pop) begin
				if (out_gap != 0)
					out_gap <= out_gap - 1;
				else
					pop <= 1'b1;
			end else if (!empty) begin
				if (out_calm != 0) begin
					g = 0;
					out_calm <= out_calm - 1;
				end else begin
					g = draw_gap();
					if ($urandom_range(0, 99) == 0)
						out_calm <= $urandom_range(40, 200);
				end
				if (g != 0) begin
					pop <= 1'b0;
					out_gap <= g - 1;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		logic [PIX_BITS-1:0] corner_px [27] = '{
			8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255,
			8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0,
			8'd8, 8'd0, 8'd7, 8'd1, 8'd6, 8'd2, 8'd5, 8'd3, 8'd4
		};
		int n, k;
		for (k = 0; k < MF3_MAX_WIDTH; k++) begin
			line_prev[k] = '0;
			line_older[k] = '0;
		end
		for (k = 0; k < WIN_TAPS; k++)
			win_taps[k] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// three 3x3 frames: majority high, majority low, distinct values
		write_reg(REG_IMAGE_WIDTH, 3);
		write_reg(REG_IMAGE_HEIGHT, 3);
		write_reg(REG_BAND_FIRST_ROW, 0);
		write_reg(REG_BAND_END_ROW, 8191);
		@(negedge clk);
		foreach (corner_px[i])
			queue_pixel(corner_px[i]);
		settle();

		// dimensions below the minimum and an empty band
		write_reg(REG_IMAGE_WIDTH, 0);
		write_reg(REG_IMAGE_HEIGHT, 2);
		write_reg(REG_BAND_FIRST_ROW, 4096);
		write_reg(REG_BAND_END_ROW, 1);
		queue_pixels(9);
		settle();

		// widest row, clamped from the all-ones value, then the rest of the frame
		// at width 3 so the column wrap of the wide row shows in the medians
		write_reg(REG_IMAGE_WIDTH, 2047);
		write_reg(REG_BAND_FIRST_ROW, 0);
		write_reg(REG_BAND_END_ROW, 8191);
		queue_pixels(MF3_MAX_WIDTH);
		settle();
		write_reg(REG_IMAGE_WIDTH, 3);
		queue_pixels(6);
		settle();

		// one 12-wide frame so both line stores hold every column used below
		write_reg(REG_IMAGE_WIDTH, 12);
		queue_pixels(36);
		settle();

		// back-pressure: receiver stalls while the sender keeps going
		write_reg(REG_IMAGE_WIDTH, 8);
		write_reg(REG_IMAGE_HEIGHT, 8);
		write_reg(REG_BAND_FIRST_ROW, 0);
		write_reg(REG_BAND_END_ROW, 8191);
		@(posedge clk);
		hold_arm <= 1'b1;
		queue_pixels(3 * 64);

		while (queued < ITEM_TARGET) begin
			settle();
			if ($urandom_range(0, 4) == 0) begin
				// part of a frame, then a change with the counters mid-frame
				n = $urandom_range(1, clamp_dim(cfg_width, MF3_MAX_WIDTH) *
					clamp_dim(cfg_height, MAX_HEIGHT));
				queue_pixels(n);
				settle();
				shuffle_reg(CFG_IDX_BITS'($urandom_range(0, 3)));
			end else begin
				for (k = 0; k < 4; k++)
					if ($urandom_range(0, 3) != 0)
						shuffle_reg(CFG_IDX_BITS'(k));
				n = $urandom_range(1, 3) * clamp_dim(cfg_width, MF3_MAX_WIDTH) *
					clamp_dim(cfg_height, MAX_HEIGHT);
				queue_pixels(n);
			end
		end

		settle();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && median_due.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
